>>> src/cltm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cltm_pkg: shared types and constants for the CPU list text parser
// Character codes, parse phase codes and the command passed from the
// front parser to the mask builder.
// ----------------------------------------------------------------------------
package cltm_pkg;

    localparam int CPU_COUNT_DEF   = 64;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int MASK_W = 64;
    localparam int IDX_W  = 6;
    localparam int NUM_W  = 32;

    localparam logic [NUM_W-1:0] RANGE_LIMIT = 32'd4096;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Parse phase codes
    localparam logic [2:0] PH_SKIP   = 3'd0;
    localparam logic [2:0] PH_FIRST  = 3'd1;
    localparam logic [2:0] PH_DASH   = 3'd2;
    localparam logic [2:0] PH_SECOND = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    // One request from the parser to the mask builder
    typedef struct packed {
        logic             apply;
        logic             emit;
        logic [NUM_W-1:0] first;
        logic [NUM_W-1:0] last;
    } cmd_t;

endpackage : cltm_pkg
`default_nettype wire

>>> src/cltm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cltm_front: character parser
// Classifies each character, accumulates decimal numbers and issues one
// range or emit request per character that closes an item or ends a string.
// ----------------------------------------------------------------------------
module cltm_front
    import cltm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] char_code,
    input  wire logic       last_char,
    input  wire logic       q_full,
    output logic            q_push,
    output cmd_t            q_cmd
);

    logic [2:0]       phase_reg,  phase_next;
    logic [NUM_W-1:0] start_reg,  start_next;
    logic [NUM_W-1:0] accum_reg,  accum_next;

    logic             is_sep, is_dig, is_dash;
    logic [NUM_W-1:0] acc_base;
    logic [NUM_W+3:0] prod;
    logic [NUM_W-1:0] acc_digit;
    logic [2:0]       ph_t;
    logic [NUM_W-1:0] acc_t, start_t;
    logic             take;
    cmd_t             cmd;

    assign is_sep  = (char_code == CH_COMMA) || (char_code == CH_SPACE) ||
                     ((char_code >= CH_TAB) && (char_code <= CH_CR));
    assign is_dig  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_dash = (char_code == CH_DASH);

    // Saturating acc * 10 + digit
    assign acc_base = (phase_reg == PH_FIRST || phase_reg == PH_SECOND) ? accum_reg : '0;
    always_comb
    begin
        prod = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1)
             + {{NUM_W{1'b0}}, 4'(char_code - CH_ZERO)};
        acc_digit = (prod[NUM_W+3:NUM_W] != 4'd0) ? {NUM_W{1'b1}} : prod[NUM_W-1:0];
    end

    always_comb
    begin
        ph_t    = phase_reg;
        acc_t   = accum_reg;
        start_t = start_reg;
        cmd     = '0;
        case (phase_reg)
            PH_SKIP:
            begin
                if (is_dig)
                begin
                    acc_t = acc_digit;
                    ph_t  = PH_FIRST;
                end
                else if (!is_sep)
                begin
                    ph_t = PH_DONE;
                end
            end
            PH_FIRST:
            begin
                if (is_dig)
                begin
                    acc_t = acc_digit;
                end
                else if (is_dash)
                begin
                    start_t = accum_reg;
                    acc_t   = '0;
                    ph_t    = PH_DASH;
                end
                else
                begin
                    cmd.apply = 1'b1;
                    cmd.first = accum_reg;
                    cmd.last  = accum_reg;
                    acc_t     = '0;
                    start_t   = '0;
                    ph_t      = is_sep ? PH_SKIP : PH_DONE;
                end
            end
            PH_DASH:
            begin
                if (is_dig)
                begin
                    acc_t = acc_digit;
                    ph_t  = PH_SECOND;
                end
                else
                begin
                    ph_t = PH_DONE;
                end
            end
            PH_SECOND:
            begin
                if (is_dig)
                begin
                    acc_t = acc_digit;
                end
                else
                begin
                    cmd.apply = 1'b1;
                    cmd.first = start_reg;
                    cmd.last  = accum_reg;
                    acc_t     = '0;
                    start_t   = '0;
                    ph_t      = is_sep ? PH_SKIP : PH_DONE;
                end
            end
            default:
            begin
                ph_t = PH_DONE;
            end
        endcase

        // Close an open item at end of string
        if (last_char)
        begin
            cmd.emit = 1'b1;
            if (ph_t == PH_FIRST)
            begin
                cmd.apply = 1'b1;
                cmd.first = acc_t;
                cmd.last  = acc_t;
            end
            else if (ph_t == PH_SECOND)
            begin
                cmd.apply = 1'b1;
                cmd.first = start_t;
                cmd.last  = acc_t;
            end
        end
    end

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;
    assign q_push   = take && (cmd.apply || cmd.emit);
    assign q_cmd    = cmd;

    always_comb
    begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        start_next = start_reg;
        if (take)
        begin
            if (last_char)
            begin
                phase_next = PH_SKIP;
                accum_next = '0;
                start_next = '0;
            end
            else
            begin
                phase_next = ph_t;
                accum_next = acc_t;
                start_next = start_t;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            accum_reg <= '0;
            start_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            start_reg <= start_next;
        end
    end

endmodule : cltm_front
`default_nettype wire

>>> src/cltm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cltm_queue: request queue between parser and mask builder
// Small register FIFO so that either side can stall on its own.
// ----------------------------------------------------------------------------
module cltm_queue
    import cltm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule : cltm_queue
`default_nettype wire

>>> src/cltm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cltm_back: mask builder
// Applies one range request per cycle to the CPU set and loads the output
// register on an emit request.
// ----------------------------------------------------------------------------
module cltm_back
    import cltm_pkg::*;
#(
    parameter int CPU_COUNT = CPU_COUNT_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               head_valid,
    input  wire cmd_t               head_cmd,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [MASK_W-1:0]       cpu_mask,
    output logic                    cpus_dropped
);

    localparam logic [NUM_W-1:0] CPU_LIMIT = NUM_W'(CPU_COUNT);
    localparam logic [IDX_W-1:0] CPU_TOP   = IDX_W'(CPU_COUNT - 1);
    localparam logic [IDX_W-1:0] MASK_TOP  = IDX_W'(MASK_W - 1);

    logic [MASK_W-1:0] set_reg,   set_next;
    logic              drop_reg,  drop_next;
    logic              ovalid_reg, ovalid_next;
    logic [MASK_W-1:0] omask_reg;
    logic              odrop_reg;

    logic              in_range, drop_hit, set_hit;
    logic [NUM_W-1:0]  span;
    logic [IDX_W-1:0]  hi_idx;
    logic [MASK_W-1:0] range_bits, set_new;
    logic              drop_new, out_free, load;

    assign span     = head_cmd.last - head_cmd.first;
    assign in_range = head_cmd.apply && (head_cmd.last >= head_cmd.first)
                      && (span < RANGE_LIMIT);
    assign drop_hit = in_range && (head_cmd.last >= CPU_LIMIT);
    assign set_hit  = in_range && (head_cmd.first < CPU_LIMIT);
    assign hi_idx   = (head_cmd.last < CPU_LIMIT) ? head_cmd.last[IDX_W-1:0] : CPU_TOP;

    always_comb
    begin
        range_bits = ({MASK_W{1'b1}} << head_cmd.first[IDX_W-1:0])
                   & ({MASK_W{1'b1}} >> (MASK_TOP - hi_idx));
        set_new  = set_reg | (set_hit ? range_bits : '0);
        drop_new = drop_reg | drop_hit;
    end

    assign out_free = !ovalid_reg || out_ready;
    assign pop      = head_valid && (!head_cmd.emit || out_free);
    assign load     = pop && head_cmd.emit;

    always_comb
    begin
        set_next    = set_reg;
        drop_next   = drop_reg;
        ovalid_next = ovalid_reg;
        if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
        if (pop)
        begin
            if (head_cmd.emit)
            begin
                set_next    = '0;
                drop_next   = 1'b0;
                ovalid_next = 1'b1;
            end
            else
            begin
                set_next  = set_new;
                drop_next = drop_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_reg    <= '0;
            drop_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            set_reg    <= set_next;
            drop_reg   <= drop_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            omask_reg <= set_new;
            odrop_reg <= drop_new;
        end
    end

    assign out_valid    = ovalid_reg;
    assign cpu_mask     = omask_reg;
    assign cpus_dropped = odrop_reg;

endmodule : cltm_back
`default_nettype wire

>>> src/cpu_list_text_to_mask.sv
`default_nettype none
// Result path: the request from the last accepted character is written into the
// request queue, then loads the output register (out_valid) when that register is free.
// Throughput: one character per cycle; the mask builder applies one range per cycle.
// A full request queue (stalled output) is the only thing that drops in_ready.
// Reset (rst_n low, asynchronous) clears the parse phase, numbers, CPU set and
// the output valid; the block takes characters in the first cycle after reset.
// ----------------------------------------------------------------------------
// cpu_list_text_to_mask: CPU list text to CPU bit mask
// Parses text such as "0-3,8,10-11" one character at a time and returns the
// listed CPUs as a bit mask on the character marked last.
// ----------------------------------------------------------------------------
module cpu_list_text_to_mask
    import cltm_pkg::*;
#(
    parameter int CPU_COUNT   = CPU_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        char_code,
    input  wire logic              last_char,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [MASK_W-1:0]      cpu_mask,
    output logic                   cpus_dropped
);

    logic q_full, q_push, q_pop, q_head_valid;
    cmd_t q_cmd, q_head_cmd;

    cltm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .last_char (last_char),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    cltm_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    cltm_back #(
        .CPU_COUNT (CPU_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (q_head_valid),
        .head_cmd     (q_head_cmd),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cpu_mask     (cpu_mask),
        .cpus_dropped (cpus_dropped)
    );

endmodule : cpu_list_text_to_mask
`default_nettype wire

>>> src/cltm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cltm_checker: port-level checks for the CPU list parser
// Watches the top level ports and flags output behavior that breaks the
// block's contract.
// ----------------------------------------------------------------------------
module cltm_checker
    import cltm_pkg::*;
#(
    parameter int CPU_COUNT = CPU_COUNT_DEF
)
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic [7:0]        char_code,
    input wire logic              last_char,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [MASK_W-1:0] cpu_mask,
    input wire logic              cpus_dropped
);

    localparam logic [MASK_W-1:0] LEGAL_BITS =
        (CPU_COUNT >= MASK_W) ? {MASK_W{1'b1}} : ((MASK_W'(1) << CPU_COUNT) - 1'b1);

    // Hold a waiting input request
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(char_code) && $stable(last_char))
        else $error("input request changed while waiting");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cpu_mask) && $stable(cpus_dropped))
        else $error("result changed while stalled");

    // No CPU at or beyond the CPU count
    a_mask_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cpu_mask & ~LEGAL_BITS) == '0)
        else $error("mask bit beyond CPU count");

    // No result right out of reset
    a_reset_quiet: assert property (@(posedge clk)
        !$past(rst_n) && rst_n |-> !out_valid)
        else $error("result valid right after reset");

    // An empty queue after reset can always take a character
    a_ready_after_reset: assert property (@(posedge clk)
        !$past(rst_n) && rst_n |-> in_ready)
        else $error("input not ready after reset");

endmodule : cltm_checker

bind cpu_list_text_to_mask cltm_checker #(.CPU_COUNT(CPU_COUNT)) u_cltm_checker (.*);
`default_nettype wire
